@@ hdl/ssrd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssrd_pkg
// Shared types and constants of the stereo silence range detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrd_pkg;

  // Saturation limit of the quiet frame counter.
  localparam int unsigned CountBits = 24;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Configuration register indexes (byte address is 4 times the index).
  localparam int unsigned CfgAddrBits = 5;
  localparam logic [2:0] RegVolumeThreshold = 3'd0;
  localparam logic [2:0] RegMinQuietRun     = 3'd1;
  localparam logic [2:0] RegMergeGap        = 3'd2;
  localparam logic [2:0] RegMinRangeLength  = 3'd3;
  localparam logic [2:0] RegEdgeMargin      = 3'd4;
  localparam logic [2:0] RegTotalFrames     = 3'd5;

  // Register values after reset.
  localparam logic [30:0] RstVolumeThreshold = 31'd12;
  localparam logic [23:0] RstMinQuietRun     = 24'd480;
  localparam logic [23:0] RstMergeGap        = 24'd48;
  localparam logic [23:0] RstMinRangeLength  = 24'd14400;
  localparam logic [23:0] RstEdgeMargin      = 24'd1606;
  localparam logic [31:0] RstTotalFrames     = 32'd1;

  // Current register contents.
  typedef struct packed {
    logic [30:0] volume_threshold;
    logic [23:0] min_quiet_run;
    logic [23:0] merge_gap;
    logic [23:0] min_range_length;
    logic [23:0] edge_margin;
    logic [31:0] total_frames;
  } ssrd_cfg_t;

  // One result entry.
  typedef struct packed {
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic        last_of_run;
  } ssrd_res_t;

  // Registered front stage status toward the core.
  typedef struct packed {
    logic valid;
    logic quiet;
  } ssrd_front_t;

endpackage

`default_nettype wire

@@ hdl/ssrd_if.sv @@
// ----------------------------------------------------------------------------
// ssrd_if
// Valid/ready channels for frames in and silence ranges out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssrd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_sample;
  logic [31:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface ssrd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] range_start;
  logic [31:0] range_end;
  logic        last_of_run;

  modport source (output valid, output range_start, output range_end,
                  output last_of_run, input ready);
  modport sink   (input valid, input range_start, input range_end,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

@@ hdl/ssrd_cfg.sv @@
// ----------------------------------------------------------------------------
// ssrd_cfg
// APB-style register file holding the detector configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrd_cfg import ssrd_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CfgAddrBits-1:0] paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ssrd_cfg_t                   cfg_o
);

  ssrd_cfg_t   cfg_q, cfg_d;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CfgAddrBits-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegVolumeThreshold: cfg_d.volume_threshold = pwdata[30:0];
        RegMinQuietRun:     cfg_d.min_quiet_run    = pwdata[23:0];
        RegMergeGap:        cfg_d.merge_gap        = pwdata[23:0];
        RegMinRangeLength:  cfg_d.min_range_length = pwdata[23:0];
        RegEdgeMargin:      cfg_d.edge_margin      = pwdata[23:0];
        RegTotalFrames:     cfg_d.total_frames     = pwdata;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume_threshold <= RstVolumeThreshold;
      cfg_q.min_quiet_run    <= RstMinQuietRun;
      cfg_q.merge_gap        <= RstMergeGap;
      cfg_q.min_range_length <= RstMinRangeLength;
      cfg_q.edge_margin      <= RstEdgeMargin;
      cfg_q.total_frames     <= RstTotalFrames;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back mux.
  always_comb begin
    case (reg_idx)
      RegVolumeThreshold: prdata = {1'b0, cfg_q.volume_threshold};
      RegMinQuietRun:     prdata = {8'd0, cfg_q.min_quiet_run};
      RegMergeGap:        prdata = {8'd0, cfg_q.merge_gap};
      RegMinRangeLength:  prdata = {8'd0, cfg_q.min_range_length};
      RegEdgeMargin:      prdata = {8'd0, cfg_q.edge_margin};
      RegTotalFrames:     prdata = cfg_q.total_frames;
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hdl/ssrd_front.sv @@
// ----------------------------------------------------------------------------
// ssrd_front
// Input register: takes a frame and stores whether both channels are quiet.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrd_front import ssrd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ssrd_in_if.sink    in_s,
  input  wire logic [30:0] threshold_i,
  input  wire logic  advance_i,
  output ssrd_front_t front_o
);

  localparam int unsigned PadBits = 33 - SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] left_raw, right_raw, left_mag, right_mag;
  logic                   quiet, valid_q, valid_d, quiet_q;

  assign left_raw  = in_s.left_sample[SAMPLE_BITS-1:0];
  assign right_raw = in_s.right_sample[SAMPLE_BITS-1:0];

  // Magnitudes; the most negative code maps to its own unsigned value.
  assign left_mag  = left_raw[SAMPLE_BITS-1]  ? (~left_raw + 1'b1)  : left_raw;
  assign right_mag = right_raw[SAMPLE_BITS-1] ? (~right_raw + 1'b1) : right_raw;

  assign quiet = ({{PadBits{1'b0}}, left_mag}  <= {2'b00, threshold_i}) &&
                 ({{PadBits{1'b0}}, right_mag} <= {2'b00, threshold_i});

  // The stage empties when the core takes the frame.
  assign in_s.ready = !valid_q || advance_i;
  assign valid_d    = in_s.valid || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) begin
      quiet_q <= quiet;
    end
  end

  assign front_o.valid = valid_q;
  assign front_o.quiet = quiet_q;

endmodule

`default_nettype wire

@@ hdl/ssrd_core.sv @@
// ----------------------------------------------------------------------------
// ssrd_core
// Quiet run counting, range open/close/merge and result formation per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrd_core import ssrd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  ssrd_cfg_t  cfg_i,
  input  ssrd_front_t front_i,
  input  wire logic  space_i,
  output logic       advance_o,
  output logic [1:0] push_cnt_o,
  output ssrd_res_t  push0_o,
  output ssrd_res_t  push1_o
);

  logic [31:0]          frame_idx_q, frame_idx_d;
  logic [CountBits-1:0] quiet_cnt_q, quiet_cnt_d, quiet_inc;
  logic                 pend_valid_q, pend_valid_d, pend_open_q, pend_open_d;
  logic [31:0]          pend_start_q, pend_start_d, pend_end_q, pend_end_d;

  logic [31:0]  run_start, stop_old, stop_new;
  logic         do_emit0, do_emit1, keep0, keep1, is_final;
  ssrd_res_t    res0, res1;

  // Drops short ranges, widens kept ones and clamps them.
  function automatic ssrd_res_t widen(input logic [31:0] start, input logic [31:0] stop,
                                      input ssrd_cfg_t c, output logic keep);
    logic [31:0] len;
    logic [32:0] wide_end;
    ssrd_res_t   r;
    len  = stop - start;
    keep = len >= {8'd0, c.min_range_length};
    r.range_start = (start > {8'd0, c.edge_margin}) ? start - {8'd0, c.edge_margin} : 32'd0;
    wide_end = {1'b0, stop} + {9'd0, c.edge_margin};
    r.range_end = (wide_end > {1'b0, c.total_frames}) ? c.total_frames : wide_end[31:0];
    r.last_of_run = 1'b0;
    return r;
  endfunction

  assign advance_o = front_i.valid && space_i;
  assign quiet_inc = quiet_cnt_q + 1'b1;
  assign run_start = frame_idx_q - {8'd0, cfg_i.min_quiet_run} + 32'd1;
  assign stop_old  = pend_open_q ? cfg_i.total_frames : pend_end_q;
  assign is_final  = ({1'b0, frame_idx_q} + 33'd1) >= {1'b0, cfg_i.total_frames};

  // Per-frame state update.
  always_comb begin
    quiet_cnt_d  = quiet_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_open_d  = pend_open_q;
    pend_start_d = pend_start_q;
    pend_end_d   = pend_end_q;
    do_emit0     = 1'b0;
    if (front_i.quiet) begin
      if (quiet_cnt_q != CountMax) begin
        quiet_cnt_d = quiet_inc;
        if (quiet_inc == cfg_i.min_quiet_run) begin
          if (pend_valid_q && !pend_open_q &&
              ((run_start - pend_end_q) < {8'd0, cfg_i.merge_gap})) begin
            pend_open_d = 1'b1;
          end else begin
            do_emit0     = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_open_d  = 1'b1;
            pend_start_d = run_start;
            pend_end_d   = 32'd0;
          end
        end
      end
    end else begin
      if (pend_open_q && (cfg_i.min_quiet_run != '0) &&
          (quiet_cnt_q >= cfg_i.min_quiet_run)) begin
        pend_end_d  = frame_idx_q - 32'd1;
        pend_open_d = 1'b0;
      end
      quiet_cnt_d = '0;
    end
  end

  assign stop_new = pend_open_d ? cfg_i.total_frames : pend_end_d;
  assign do_emit1 = is_final && pend_valid_d;

  // Result formation: displaced range first, then the end-of-stream flush.
  always_comb begin
    ssrd_res_t r0, r1;
    logic      k0, k1;
    r0 = widen(pend_start_q, stop_old, cfg_i, k0);
    r1 = widen(pend_start_d, stop_new, cfg_i, k1);
    keep0 = do_emit0 && k0;
    keep1 = do_emit1 && k1;
    res0  = r0;
    res1  = r1;
    res0.last_of_run = !keep1;
    res1.last_of_run = 1'b1;
    push0_o = keep0 ? res0 : res1;
    push1_o = res1;
    push_cnt_o = advance_o ? ({1'b0, keep0} + {1'b0, keep1}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_idx_q  <= 32'd0;
      quiet_cnt_q  <= '0;
      pend_valid_q <= 1'b0;
      pend_open_q  <= 1'b0;
      pend_start_q <= 32'd0;
      pend_end_q   <= 32'd0;
    end else if (advance_o) begin
      if (is_final) begin
        frame_idx_q  <= 32'd0;
        quiet_cnt_q  <= '0;
        pend_valid_q <= 1'b0;
        pend_open_q  <= 1'b0;
        pend_start_q <= 32'd0;
        pend_end_q   <= 32'd0;
      end else begin
        frame_idx_q  <= frame_idx_d;
        quiet_cnt_q  <= quiet_cnt_d;
        pend_valid_q <= pend_valid_d;
        pend_open_q  <= pend_open_d;
        pend_start_q <= pend_start_d;
        pend_end_q   <= pend_end_d;
      end
    end
  end

  assign frame_idx_d = frame_idx_q + 32'd1;

endmodule

`default_nettype wire

@@ hdl/ssrd_fifo.sv @@
// ----------------------------------------------------------------------------
// ssrd_fifo
// Four-entry result queue taking up to two results per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrd_fifo import ssrd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic [1:0] push_cnt_i,
  input  ssrd_res_t  push0_i,
  input  ssrd_res_t  push1_i,
  output logic       space_o,
  ssrd_out_if.source out_m
);

  ssrd_res_t  mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q, wr_next;
  logic [2:0] count_q;
  logic       pop;

  // Room for the largest burst of one frame.
  assign space_o = count_q <= 3'd2;
  assign pop     = out_m.valid && out_m.ready;
  assign wr_next = wr_ptr_q + 2'd1;

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_cnt_i;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      count_q  <= count_q + {1'b0, push_cnt_i} - {2'b00, pop};
    end
  end

  assign out_m.valid       = count_q != 3'd0;
  assign out_m.range_start = mem_q[rd_ptr_q].range_start;
  assign out_m.range_end   = mem_q[rd_ptr_q].range_end;
  assign out_m.last_of_run = mem_q[rd_ptr_q].last_of_run;

endmodule

`default_nettype wire

@@ hdl/stereo_silence_range_detector_unit.sv @@
// ----------------------------------------------------------------------------
// stereo_silence_range_detector_unit
// Finds silence ranges in a stream of stereo PCM frames.
// ----------------------------------------------------------------------------
// Frames enter on in_s (valid/ready), one transaction per frame. Each frame
// may produce zero, one or two silence ranges on out_m, the last of them
// flagged by last_of_run. Registers are to be set over the APB-style port
// while the block is idle (not enforced by the block); pready is always high.
// A frame is accepted in every cycle as long as the four-entry result queue
// has room for two results, so the sustained rate is one frame per cycle.
// A frame's transaction loads it into the input register; its results then
// pass through the range logic into the result queue, which drives out_m,
// once the queue has room for two results. When the receiver stalls, the
// queue fills, and in_s.ready drops once the input register holds a frame
// and fewer than two entries are free; nothing is lost.
// Reset clears the stream state and the queue and loads the register
// defaults; the frame following reset is frame zero of a new stream.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_silence_range_detector_unit import ssrd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  ssrd_in_if.sink                     in_s,
  ssrd_out_if.source                  out_m,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CfgAddrBits-1:0] paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  ssrd_cfg_t   cfg;
  ssrd_front_t front;
  ssrd_res_t   push0, push1;
  logic [1:0]  push_cnt;
  logic        advance, space;

  // Configuration registers.
  ssrd_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  // Input register and quiet detection.
  ssrd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni, .in_s,
    .threshold_i (cfg.volume_threshold),
    .advance_i   (advance),
    .front_o     (front)
  );

  // Range tracking.
  ssrd_core u_core (
    .clk_i, .rst_ni,
    .cfg_i      (cfg),
    .front_i    (front),
    .space_i    (space),
    .advance_o  (advance),
    .push_cnt_o (push_cnt),
    .push0_o    (push0),
    .push1_o    (push1)
  );

  // Result queue.
  ssrd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_cnt_i (push_cnt),
    .push0_i    (push0),
    .push1_i    (push1),
    .space_o    (space),
    .out_m
  );

endmodule

`default_nettype wire
